// ===== hdl/sps_pkg.sv =====
// ----------------------------------------------------------------------------
// sps_pkg
// Shared types and constants for the servo pulse smoother.
// ----------------------------------------------------------------------------
package sps_pkg;

  typedef enum logic [1:0] {
    CFG_MIN_PULSE = 2'd0,
    CFG_MAX_PULSE = 2'd1,
    CFG_DEADBAND  = 2'd2,
    CFG_GAIN      = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [11:0] lo_us;
    logic [11:0] hi_us;
    logic [15:0] deadband;
    logic [8:0]  gain;
  } sps_cfg_t;

  localparam logic [11:0] MinPulseReset = 12'd1000;
  localparam logic [11:0] MaxPulseReset = 12'd2000;
  localparam logic [15:0] DeadbandReset = 16'd1280;
  localparam logic [8:0]  GainReset     = 9'd26;

  localparam logic [19:0] PosResetQ8 = 20'd384000;
  localparam logic [19:0] PosMaxQ8   = 20'hFFFFF;
  localparam logic [19:0] SnapQ8     = 20'd128;
  localparam logic [8:0]  GainOne    = 9'd256;

  localparam logic signed [23:0] TargetCenterQ9 = 24'sd768000;
  localparam logic signed [23:0] UsPerUnitQ9    = 24'sd125;

  // floor(p * 65536 / 20000) == (p * ceil(2^33 / 625)) >> 22 for p < 4096
  localparam logic [23:0] DutyRecip = 24'd13743896;
  localparam int unsigned DutyShift = 22;

endpackage

// ===== hdl/sps_target.sv =====
// ----------------------------------------------------------------------------
// sps_target
// Steering to clamped target position in microseconds, Q.8.
// ----------------------------------------------------------------------------
module sps_target (
  input  logic signed [15:0] steering_i,
  input  sps_pkg::sps_cfg_t  cfg_i,
  output logic [19:0]        target_q8_o
);
  import sps_pkg::*;

  logic signed [23:0] steer_ext;
  logic signed [23:0] t2;
  logic signed [23:0] lo;
  logic signed [23:0] hi;
  logic signed [23:0] t2_lo;
  logic signed [23:0] t2_clamped;

  always_comb begin
    steer_ext  = {{8{steering_i[15]}}, steering_i};
    t2         = TargetCenterQ9 + steer_ext * UsPerUnitQ9;
    lo         = $signed({3'b000, cfg_i.lo_us, 9'd0});
    hi         = $signed({3'b000, cfg_i.hi_us, 9'd0});
    t2_lo      = (t2 < lo) ? lo : t2;
    t2_clamped = (t2_lo > hi) ? hi : t2_lo;
  end

  // drop the Q.9 half bit
  assign target_q8_o = t2_clamped[20:1];

endmodule

// ===== hdl/sps_track.sv =====
// ----------------------------------------------------------------------------
// sps_track
// Position update with deadband, snap and smoothing, plus pulse clamp.
// ----------------------------------------------------------------------------
module sps_track (
  input  logic [19:0]       target_q8_i,
  input  logic [19:0]       pos_q8_i,
  input  sps_pkg::sps_cfg_t cfg_i,
  output logic [19:0]       pos_q8_o,
  output logic [11:0]       pulse_us_o
);
  import sps_pkg::*;

  logic signed [20:0] diff;
  logic signed [20:0] mag_full;
  logic [19:0]        mag;
  logic [8:0]         gain_sat;
  logic [28:0]        prod;
  logic [28:0]        prod_rnd;
  logic [20:0]        step;
  logic signed [21:0] pos_ext;
  logic signed [21:0] step_ext;
  logic signed [21:0] pos_nxt;
  logic [11:0]        whole_us;
  logic [11:0]        pulse_lo;

  always_comb begin
    diff     = $signed({1'b0, target_q8_i}) - $signed({1'b0, pos_q8_i});
    mag_full = diff[20] ? -diff : diff;
    mag      = mag_full[19:0];
    gain_sat = (cfg_i.gain > GainOne) ? GainOne : cfg_i.gain;
    prod     = {9'd0, mag} * {20'd0, gain_sat};
    prod_rnd = prod + 29'd128;
    step     = prod_rnd[28:8];
    pos_ext  = $signed({2'b00, pos_q8_i});
    step_ext = $signed({1'b0, step});

    priority if (mag > {4'd0, cfg_i.deadband}) begin
      pos_nxt = diff[20] ? (pos_ext - step_ext) : (pos_ext + step_ext);
    end else if (mag > SnapQ8) begin
      pos_nxt = $signed({2'b00, target_q8_i});
    end else begin
      pos_nxt = pos_ext;
    end

    priority if (pos_nxt[21]) begin
      pos_q8_o = '0;
    end else if (pos_nxt[20]) begin
      pos_q8_o = PosMaxQ8;
    end else begin
      pos_q8_o = pos_nxt[19:0];
    end

    whole_us   = pos_q8_o[19:8];
    pulse_lo   = (whole_us < cfg_i.lo_us) ? cfg_i.lo_us : whole_us;
    pulse_us_o = (pulse_lo > cfg_i.hi_us) ? cfg_i.hi_us : pulse_lo;
  end

endmodule

// ===== hdl/sps_duty.sv =====
// ----------------------------------------------------------------------------
// sps_duty
// Pulse width to 16-bit timer duty count over a 20000 us period.
// ----------------------------------------------------------------------------
module sps_duty (
  input  logic [11:0] pulse_us_i,
  output logic [13:0] duty_o
);
  import sps_pkg::*;

  logic [35:0] prod;

  assign prod   = {24'd0, pulse_us_i} * {12'd0, DutyRecip};
  assign duty_o = prod[DutyShift +: 14];

endmodule

// ===== hdl/servo_pulse_smoother.sv =====
// ----------------------------------------------------------------------------
// servo_pulse_smoother
// Smoothed servo pulse width and timer duty from a steering request stream.
// ----------------------------------------------------------------------------
// Each steering request yields one result of pulse width and duty count. The
// block takes one request per cycle while the result side does not stall, and
// returns its result after these steps: the target is registered at the
// input, the position update closes around the position register, and the
// duty multiply has a stage of its own ahead of the output register. The
// position loop sets the rate. Backpressure on the result side stalls the
// stages in order and finally drops s_axis_tready. Write configuration only
// while no request is in flight; reset loads 1000/2000 us limits, a 5 us
// deadband, gain 26/256 and a 1500 us position.
module servo_pulse_smoother (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] steering
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [11:0] pulse_us, [25:12] duty, zero pad
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_addr_i,
  input  logic [15:0] cfg_wdata_i
);
  import sps_pkg::*;

  sps_cfg_t    cfg_q;

  logic        s1_valid_q;
  logic [19:0] s1_target_q;
  logic        s2_valid_q;
  logic [11:0] s2_pulse_q;
  logic        out_valid_q;
  logic [11:0] out_pulse_q;
  logic [13:0] out_duty_q;
  logic [19:0] pos_q;
  logic [19:0] pos_d;

  logic [19:0] target_d;
  logic [11:0] pulse_d;
  logic [13:0] duty_d;
  logic        out_ready;
  logic        s2_ready;
  logic        s1_ready;
  logic        s1_advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.lo_us    <= MinPulseReset;
      cfg_q.hi_us    <= MaxPulseReset;
      cfg_q.deadband <= DeadbandReset;
      cfg_q.gain     <= GainReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_addr_i))
        CFG_MIN_PULSE: cfg_q.lo_us    <= cfg_wdata_i[11:0];
        CFG_MAX_PULSE: cfg_q.hi_us    <= cfg_wdata_i[11:0];
        CFG_DEADBAND:  cfg_q.deadband <= cfg_wdata_i;
        CFG_GAIN:      cfg_q.gain     <= cfg_wdata_i[8:0];
      endcase
    end
  end

  assign out_ready     = !out_valid_q || m_axis_tready;
  assign s2_ready      = !s2_valid_q || out_ready;
  assign s1_ready      = !s1_valid_q || s2_ready;
  assign s1_advance    = s1_valid_q && s2_ready;
  assign s_axis_tready = s1_ready;

  sps_target u_target (
    .steering_i  ($signed(s_axis_tdata)),
    .cfg_i       (cfg_q),
    .target_q8_o (target_d)
  );

  sps_track u_track (
    .target_q8_i (s1_target_q),
    .pos_q8_i    (pos_q),
    .cfg_i       (cfg_q),
    .pos_q8_o    (pos_d),
    .pulse_us_o  (pulse_d)
  );

  sps_duty u_duty (
    .pulse_us_i (s2_pulse_q),
    .duty_o     (duty_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      pos_q       <= PosResetQ8;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= s_axis_tvalid;
      end
      if (s2_ready) begin
        s2_valid_q <= s1_valid_q;
      end
      if (out_ready) begin
        out_valid_q <= s2_valid_q;
      end
      if (s1_advance) begin
        pos_q <= pos_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && s_axis_tvalid) begin
      s1_target_q <= target_d;
    end
    if (s1_advance) begin
      s2_pulse_q <= pulse_d;
    end
    if (out_ready && s2_valid_q) begin
      out_pulse_q <= s2_pulse_q;
      out_duty_q  <= duty_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_duty_q, out_pulse_q};

`ifndef SYNTHESIS
  a_pos_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_advance |=> $stable(pos_q))
    else $error("position moved without a request advancing");

  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready && s2_valid_q && s1_valid_q) |-> !s_axis_tready)
    else $error("request accepted while pipeline is full and stalled");

  a_pulse_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (cfg_q.lo_us <= cfg_q.hi_us)) |->
      ((out_pulse_q >= cfg_q.lo_us) && (out_pulse_q <= cfg_q.hi_us)))
    else $error("pulse width outside configured limits");

  a_duty_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (out_duty_q <= 14'd13418))
    else $error("duty count above full-scale value");
`endif

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the servo pulse smoother.
// ----------------------------------------------------------------------------
// Steering requests go in through the input stream in bursts with random gaps.
// A local copy of the position tracker predicts the pulse width and duty count
// of every accepted request. Each result leaving the output stream is compared
// with the oldest prediction. Directed tests cover the steering extremes, the
// gain and limit corners, inverted limits and masked register writes. A stall
// test holds the output side off until the input stalls. Random phases then
// run slowly varying steering around changing register settings.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sps_pkg::*;

  typedef struct {
    logic [11:0] pulse;
    logic [13:0] duty;
  } servo_out_t;

  localparam longint CenterQ9    = 768000;
  localparam longint StepQ9      = 125;
  localparam longint SnapLimitQ8 = 128;
  localparam longint PosCeilQ8   = 1048575;
  localparam longint FullGain    = 256;
  localparam longint PeriodUs    = 20000;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        cfg_we_i      = 1'b0;
  logic [1:0]  cfg_addr_i    = '0;
  logic [15:0] cfg_wdata_i   = '0;

  logic [11:0] min_us      = 12'd1000;
  logic [11:0] max_us      = 12'd2000;
  logic [15:0] deadband_q8 = 16'd1280;
  logic [8:0]  gain_q8     = 9'd26;
  logic [19:0] pos_q8      = 20'd384000;

  servo_out_t pending_pulses[$];
  int mismatches  = 0;
  int burst_left  = 0;
  int hold_cycles = 0;
  int ready_mode  = 0;
  int mode_left   = 0;

  servo_pulse_smoother uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [15:0] steering
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // [11:0] pulse_us, [25:12] duty
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #3_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic servo_out_t advance_position(input logic signed [15:0] steer);
    servo_out_t res;
    longint lo, hi, t2, target, diff, mag, step, pos, whole, g;
    lo = longint'(min_us) * 512;
    hi = longint'(max_us) * 512;
    t2 = CenterQ9 + longint'(steer) * StepQ9;
    if (t2 < lo) t2 = lo;
    if (t2 > hi) t2 = hi;
    target = t2 / 2;
    pos = longint'(pos_q8);
    diff = target - pos;
    mag = (diff < 0) ? -diff : diff;
    if (mag > longint'(deadband_q8)) begin
      g = (longint'(gain_q8) > FullGain) ? FullGain : longint'(gain_q8);
      step = (mag * g + 128) / 256;
      pos = (diff < 0) ? pos - step : pos + step;
    end else if (mag > SnapLimitQ8) begin
      pos = target;
    end
    if (pos < 0) pos = 0;
    if (pos > PosCeilQ8) pos = PosCeilQ8;
    pos_q8 = 20'(pos);
    whole = pos / 256;
    if (whole < longint'(min_us)) whole = longint'(min_us);
    if (whole > longint'(max_us)) whole = longint'(max_us);
    res.pulse = 12'(whole);
    res.duty  = 14'((whole * 65536) / PeriodUs);
    return res;
  endfunction

  task automatic flag_mismatch(input string what, input longint want, input longint got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch at %0t: %s expected %0d got %0d", $realtime, what, want, got);
  endtask

  always @(posedge clk_i) begin : result_check
    servo_out_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_pulses.size() == 0) begin
        flag_mismatch("unexpected result, pulse", -1, m_axis_tdata[11:0]);
      end else begin
        want = pending_pulses.pop_front();
        if (m_axis_tdata[11:0] !== want.pulse)
          flag_mismatch("pulse_us", want.pulse, m_axis_tdata[11:0]);
        if (m_axis_tdata[25:12] !== want.duty)
          flag_mismatch("duty", want.duty, m_axis_tdata[25:12]);
      end
    end
  end

  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_axis_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        ready_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(5, 60);
      end else begin
        mode_left--;
      end
      case (ready_mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= ($urandom_range(0, 1) == 0);
        2: m_axis_tready <= ($urandom_range(0, 3) == 0);
        default: m_axis_tready <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  task automatic send_request(input logic [15:0] steer);
    int gap;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 20);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= steer;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_pulses.push_back(advance_position(steer));
    burst_left--;
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_pulses.size() != 0) @(posedge clk_i);
  endtask

  task automatic apply_config(input logic [15:0] lo_v, input logic [15:0] hi_v,
                              input logic [15:0] db_v, input logic [15:0] gain_v);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= CFG_MIN_PULSE;
    cfg_wdata_i <= lo_v;
    @(posedge clk_i);
    cfg_addr_i  <= CFG_MAX_PULSE;
    cfg_wdata_i <= hi_v;
    @(posedge clk_i);
    cfg_addr_i  <= CFG_DEADBAND;
    cfg_wdata_i <= db_v;
    @(posedge clk_i);
    cfg_addr_i  <= CFG_GAIN;
    cfg_wdata_i <= gain_v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    min_us      = lo_v[11:0];
    max_us      = hi_v[11:0];
    deadband_q8 = db_v;
    gain_q8     = gain_v[8:0];
  endtask

  task automatic test_reset_config();
    logic [15:0] steer_set[5];
    steer_set = '{16'h7FFF, 16'h8000, 16'h0000, 16'h1000, 16'hF000};
    foreach (steer_set[i]) send_request(steer_set[i]);
  endtask

  task automatic test_gain_limits();
    apply_config(16'd0, 16'd4095, 16'd1280, 16'd256);
    send_request(16'h0000);
    send_request(16'h0003);
    send_request(16'h0001);
    apply_config(16'd0, 16'd4095, 16'd1280, 16'd511);
    send_request(16'h1000);
    apply_config(16'd0, 16'd4095, 16'd1280, 16'd0);
    send_request(16'hF000);
    send_request(16'h0010);
  endtask

  task automatic test_clamp_limits();
    apply_config(16'hF000, 16'hAFFF, 16'hFFFF, 16'd26);
    send_request(16'h7FFF);
    send_request(16'h8000);
    apply_config(16'd1000, 16'd2000, 16'd0, 16'hFF01);
    send_request(16'h0002);
    send_request(16'h7FFF);
    apply_config(16'd3000, 16'd100, 16'd1280, 16'd128);
    send_request(16'h0000);
    send_request(16'h8000);
  endtask

  task automatic test_input_stall();
    apply_config(16'd500, 16'd2500, 16'd640, 16'd64);
    hold_cycles = 120;
    burst_left = 1000;
    repeat (40) send_request(16'($urandom_range(0, 12000)) - 16'd6000);
    burst_left = 0;
  endtask

  task automatic test_random_tracking();
    int lo, hi, db, g, aim, run, sent;
    for (int phase = 0; phase < 10; phase++) begin
      case (phase)
        0: begin
          lo = 0;
          hi = 4095;
        end
        1: begin
          lo = $urandom_range(1600, 4095);
          hi = $urandom_range(0, 1500);
        end
        default: begin
          lo = $urandom_range(0, 2000);
          hi = $urandom_range(lo, 4095);
        end
      endcase
      db = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 4000);
      g  = $urandom_range(0, 511);
      apply_config({4'($urandom), 12'(lo)}, {4'($urandom), 12'(hi)}, 16'(db),
                   {7'($urandom), 9'(g)});
      sent = 0;
      while (sent < 110) begin
        if ($urandom_range(0, 6) == 0) begin
          send_request(16'($urandom));
          sent++;
        end else begin
          aim = int'($urandom_range(0, 10000)) - 5000;
          run = $urandom_range(1, 30);
          repeat (run) begin
            send_request(16'(aim + int'($urandom_range(0, 6)) - 3));
            sent++;
          end
        end
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_config();
    test_gain_limits();
    test_clamp_limits();
    test_input_stall();
    test_random_tracking();
    drain_results();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && pending_pulses.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
